/* rtl/core/ewts_pkg.sv */
// ----------------------------------------------------------------------------
// ewts_pkg
// Shared constants, codes and types of the event wakeup task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ewts_pkg;

    // sizing
    localparam int NUM_SLOTS = 16;
    localparam int MASK_BITS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RESET_CUR = (NUM_SLOTS > 14) ? 14 : NUM_SLOTS - 1;

    // port field widths
    localparam int ACT_W      = 3;
    localparam int IN_MASK_W  = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_MASK_W = 16;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LATER   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_URGENT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_YIELD   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TRIGGER = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ABORT   = 3'd5;

    // slot state codes
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    // result status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [MASK_BITS-1:0] t_mask;

    // per-slot decision from the shared match unit
    typedef struct packed {
        logic pick;     // slot qualifies for the lowest-slot search
        logic wake;     // slot goes back to running
        logic wr_mask;  // slot stores the fired mask
    } t_match;

endpackage

`default_nettype wire

/* rtl/core/ewts_if.sv */
// ----------------------------------------------------------------------------
// ewts_if
// Valid/ready channels for scheduler action beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ewts_in_if;
    logic                          valid;
    logic                          ready;
    logic [ewts_pkg::ACT_W-1:0]     action;
    logic [ewts_pkg::IN_MASK_W-1:0] trigger_mask;

    modport source (output valid, output action, output trigger_mask, input ready);
    modport sink   (input valid, input action, input trigger_mask, output ready);
endinterface

interface ewts_out_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [ewts_pkg::OUT_IDX_W-1:0]  slot_index;
    logic [ewts_pkg::OUT_IDX_W-1:0]  current_index;
    logic [ewts_pkg::OUT_MASK_W-1:0] wake_mask;

    modport source (output valid, output status, output slot_index,
                    output current_index, output wake_mask, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input current_index, input wake_mask, output ready);
endinterface

`default_nettype wire

/* rtl/core/ewts_mask_ram.sv */
// ----------------------------------------------------------------------------
// ewts_mask_ram
// Slot mask store: one write port, one registered read port, per-entry
// valid bits so that an unwritten entry reads as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ewts_mask_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  ewts_pkg::t_slot    i_waddr,
    input  ewts_pkg::t_mask    i_wdata,
    input  logic               i_re,
    input  ewts_pkg::t_slot    i_raddr,
    output ewts_pkg::t_mask    o_rdata
);

    ewts_pkg::t_mask r_mem [ewts_pkg::NUM_SLOTS];
    logic [ewts_pkg::NUM_SLOTS-1:0] r_vld;
    ewts_pkg::t_mask r_rdata;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/ewts_match.sv */
// ----------------------------------------------------------------------------
// ewts_match
// Shared per-slot compare unit: judges one slot's state and mask against
// the current action during the slot sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module ewts_match (
    input  logic [ewts_pkg::ACT_W-1:0] i_act,
    input  logic [1:0]                 i_st,
    input  ewts_pkg::t_mask            i_mask,
    input  ewts_pkg::t_mask            i_fire,
    output ewts_pkg::t_match           o_res
);

    logic w_waiting;
    logic w_overlap;
    logic w_zero;

    assign w_waiting = (i_st == ewts_pkg::ST_WAIT);
    assign w_overlap = |(i_mask & i_fire);
    assign w_zero    = (i_mask == '0);

    // decision per action
    always_comb begin
        o_res = '0;
        case (i_act)
            ewts_pkg::ACT_LATER, ewts_pkg::ACT_URGENT: begin
                o_res.pick = (i_st == ewts_pkg::ST_FREE);
            end
            ewts_pkg::ACT_YIELD, ewts_pkg::ACT_ABORT: begin
                o_res.pick = (i_st == ewts_pkg::ST_RUN);
            end
            ewts_pkg::ACT_TRIGGER: begin
                o_res.wake    = w_waiting && w_overlap;
                o_res.wr_mask = w_waiting && w_overlap;
            end
            ewts_pkg::ACT_TICK: begin
                o_res.wake = w_waiting && w_zero;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/event_wakeup_task_scheduler_top.sv */
// ----------------------------------------------------------------------------
// event_wakeup_task_scheduler_top
// Task-slot scheduler: allocate, yield, trigger, tick and abort over a
// sweep of all slots through one shared compare unit.
// ----------------------------------------------------------------------------
// Flow: each action beat passes S_PREP, the slot sweep, S_FIN, S_RD and S_OUT
//   before its result is registered; the sweep visits one slot at a time,
//   bound by the single read port of the mask RAM.
// Input is taken only while the sequencer is idle; a waiting result beat
//   does not block acceptance of the next action.
// Reset: synchronous active low; slot 0 running, others free, current slot 14.
`default_nettype none

module event_wakeup_task_scheduler_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ewts_in_if.sink       i_in,
    ewts_out_if.source    o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SWRD = 3'd2;
    localparam logic [2:0] S_SWEV = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                 r_state;
    logic [ewts_pkg::ACT_W-1:0] r_act;
    ewts_pkg::t_mask            r_fire;
    ewts_pkg::t_slot            r_idx;
    ewts_pkg::t_slot            r_pick;
    logic                       r_found;
    ewts_pkg::t_slot            r_cur;
    ewts_pkg::t_slot            r_alloc;
    logic                       r_full;
    logic [1:0]                 r_status [ewts_pkg::NUM_SLOTS];

    logic                              r_ov;
    logic                              r_ostat;
    logic [ewts_pkg::OUT_IDX_W-1:0]    r_oslot;
    logic [ewts_pkg::OUT_IDX_W-1:0]    r_ocur;
    logic [ewts_pkg::OUT_MASK_W-1:0]   r_omask;

    logic              w_acc;
    logic              w_cap;
    logic              w_last;
    logic              w_invoke;
    logic              w_switch;
    logic              w_we;
    ewts_pkg::t_slot   w_waddr;
    ewts_pkg::t_mask   w_wdata;
    logic              w_re;
    ewts_pkg::t_slot   w_raddr;
    ewts_pkg::t_mask   w_rdata;
    ewts_pkg::t_match  w_m;

    assign w_acc    = i_in.valid && i_in.ready;
    assign w_cap    = (r_state == S_OUT) && (!r_ov || o_out.ready);
    assign w_last   = (r_idx == ewts_pkg::SLOT_W'(ewts_pkg::NUM_SLOTS - 1));
    assign w_invoke = (r_act == ewts_pkg::ACT_LATER) || (r_act == ewts_pkg::ACT_URGENT);
    assign w_switch = (r_act == ewts_pkg::ACT_YIELD) || (r_act == ewts_pkg::ACT_ABORT);

    assign i_in.ready = (r_state == S_IDLE);

    // shared compare unit
    ewts_match u_match (
        .i_act  (r_act),
        .i_st   (r_status[r_idx]),
        .i_mask (w_rdata),
        .i_fire (r_fire),
        .o_res  (w_m)
    );

    // mask ram port steering
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_fire;
        w_re    = 1'b0;
        w_raddr = r_idx;
        case (r_state)
            S_PREP: begin
                w_we    = (r_act == ewts_pkg::ACT_YIELD);
                w_waddr = r_cur;
            end
            S_SWRD: begin
                w_re = 1'b1;
            end
            S_SWEV: begin
                w_we = w_m.wr_mask;
            end
            S_FIN: begin
                w_we    = w_invoke && r_found;
                w_waddr = r_pick;
                w_wdata = '0;
            end
            S_RD: begin
                w_re    = 1'b1;
                w_raddr = r_cur;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    ewts_mask_ram u_mask_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= ewts_pkg::SLOT_W'(ewts_pkg::RESET_CUR);
            r_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_SWRD;
                end
                S_SWRD: begin
                    r_state <= S_SWEV;
                end
                S_SWEV: begin
                    if (w_m.pick && !r_found) begin
                        r_found <= 1'b1;
                    end
                    r_state <= w_last ? S_FIN : S_SWRD;
                end
                S_FIN: begin
                    if (r_act == ewts_pkg::ACT_URGENT && r_found) begin
                        r_cur <= r_pick;
                    end else if (w_switch) begin
                        r_cur <= r_found ? r_pick : '0;
                    end
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_cap) begin
                        r_state <= S_IDLE;
                        r_found <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // action context and sweep index
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_act  <= i_in.action;
            r_fire <= ewts_pkg::MASK_BITS'(i_in.trigger_mask);
            r_idx  <= '0;
        end else if (r_state == S_SWEV) begin
            if (w_m.pick && !r_found) begin
                r_pick <= r_idx;
            end
            if (!w_last) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (r_state == S_FIN) begin
            r_alloc <= (w_invoke && r_found) ? r_pick : '0;
            r_full  <= w_invoke && !r_found;
        end
    end

    // slot states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ewts_pkg::NUM_SLOTS; i++) begin
                r_status[i] <= (i == 0) ? ewts_pkg::ST_RUN : ewts_pkg::ST_FREE;
            end
        end else begin
            case (r_state)
                S_PREP: begin
                    if (r_act == ewts_pkg::ACT_YIELD) begin
                        r_status[r_cur] <= ewts_pkg::ST_WAIT;
                    end else if (r_act == ewts_pkg::ACT_ABORT) begin
                        r_status[r_cur] <= ewts_pkg::ST_FREE;
                    end
                end
                S_SWEV: begin
                    if (w_m.wake) begin
                        r_status[r_idx] <= ewts_pkg::ST_RUN;
                    end
                end
                S_FIN: begin
                    if (w_invoke && r_found) begin
                        r_status[r_pick] <= ewts_pkg::ST_RUN;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_cap) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_ostat <= r_full ? ewts_pkg::STAT_FULL : ewts_pkg::STAT_OK;
            r_oslot <= ewts_pkg::OUT_IDX_W'(r_alloc);
            r_ocur  <= ewts_pkg::OUT_IDX_W'(r_cur);
            r_omask <= ewts_pkg::OUT_MASK_W'(w_rdata);
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.status        = r_ostat;
    assign o_out.slot_index    = r_oslot;
    assign o_out.current_index = r_ocur;
    assign o_out.wake_mask     = r_omask;

    // full status only ever follows an invoke
    a_full_on_invoke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cap |=> (r_ostat == ewts_pkg::STAT_OK || w_invoke))
        else $error("full status reported for a non-invoke action");

    // current slot stays inside the slot range
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= ewts_pkg::SLOT_W'(ewts_pkg::NUM_SLOTS - 1))
        else $error("current slot out of range");

    // urgent invoke makes the allocated slot current
    a_urgent_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_act == ewts_pkg::ACT_URGENT && r_found)
        |=> (r_cur == r_alloc))
        else $error("urgent invoke did not switch to the new slot");

    // a switch lands on a running slot or falls back to slot zero
    a_switch_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_switch)
        |=> (r_status[r_cur] == ewts_pkg::ST_RUN || r_cur == '0))
        else $error("switch picked a slot that is not running");

    // no new action beat while the sweep is in progress
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWRD || r_state == S_SWEV) |-> !w_acc)
        else $error("action accepted during slot sweep");

endmodule

`default_nettype wire

/* tb/sv/event_wakeup_task_scheduler_top_tb.sv */
// ----------------------------------------------------------------------------
// event_wakeup_task_scheduler_top_tb
// Drives scheduler actions into the block and compares every result beat
// with a cycle-free scheduler model kept alongside. Directed sequences hit
// the idle, switch, wake and full paths. Random phases with changing
// backpressure then follow.
// ----------------------------------------------------------------------------
`default_nettype none

module event_wakeup_task_scheduler_top_tb;

    // codes the block ignores
    localparam logic [ewts_pkg::ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ewts_pkg::ACT_W-1:0] ACT_RSVD7 = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * ewts_pkg::NUM_SLOTS + 8;

    typedef struct packed {
        logic                            status;
        logic [ewts_pkg::OUT_IDX_W-1:0]  slot_index;
        logic [ewts_pkg::OUT_IDX_W-1:0]  current_index;
        logic [ewts_pkg::OUT_MASK_W-1:0] wake_mask;
    } t_sched_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ewts_in_if  in_bus ();
    ewts_out_if out_bus ();

    event_wakeup_task_scheduler_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // shadow scheduler state
    logic [1:0]      slot_state [ewts_pkg::NUM_SLOTS];
    ewts_pkg::t_mask slot_wait_mask [ewts_pkg::NUM_SLOTS];
    int unsigned     current_q;

    t_sched_result pending_results [$];
    t_sched_result want;

    int src_gap_pct     = 11;
    int snk_gap_pct     = 49;
    int mismatch_count  = 0;
    int results_checked = 0;
    int full_count      = 0;
    int cycle_count     = 0;
    int action_count [8] = '{default: 0};

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void reset_scheduler();
        for (int n = 0; n < ewts_pkg::NUM_SLOTS; n++) begin
            slot_state[n]     = ewts_pkg::ST_FREE;
            slot_wait_mask[n] = '0;
        end
        slot_state[0] = ewts_pkg::ST_RUN;
        current_q     = ewts_pkg::RESET_CUR;
    endfunction

    // lowest slot in a state, NUM_SLOTS when none
    function automatic int lowest_slot(input logic [1:0] st);
        for (int n = 0; n < ewts_pkg::NUM_SLOTS; n++)
            if (slot_state[n] == st)
                return n;
        return ewts_pkg::NUM_SLOTS;
    endfunction

    // lowest running slot, slot 0 when nothing runs
    function automatic int next_current();
        int pick;
        pick = lowest_slot(ewts_pkg::ST_RUN);
        return (pick >= ewts_pkg::NUM_SLOTS) ? 0 : pick;
    endfunction

    // apply one action to the shadow state and form its result
    function automatic t_sched_result apply_action(
        input logic [ewts_pkg::ACT_W-1:0]     act,
        input logic [ewts_pkg::IN_MASK_W-1:0] raw_mask);
        t_sched_result   res;
        ewts_pkg::t_mask fired;
        int              cur;
        int              pick;
        res   = '0;
        fired = ewts_pkg::t_mask'(raw_mask);
        cur   = current_q % ewts_pkg::NUM_SLOTS;
        case (act)
            ewts_pkg::ACT_LATER, ewts_pkg::ACT_URGENT: begin
                pick = lowest_slot(ewts_pkg::ST_FREE);
                if (pick >= ewts_pkg::NUM_SLOTS) begin
                    res.status = ewts_pkg::STAT_FULL;
                end else begin
                    slot_state[pick]     = ewts_pkg::ST_RUN;
                    slot_wait_mask[pick] = '0;
                    res.slot_index       = ewts_pkg::OUT_IDX_W'(pick);
                    if (act == ewts_pkg::ACT_URGENT)
                        current_q = pick;
                end
            end
            ewts_pkg::ACT_YIELD: begin
                slot_state[cur]     = ewts_pkg::ST_WAIT;
                slot_wait_mask[cur] = fired;
                current_q           = next_current();
            end
            ewts_pkg::ACT_TRIGGER: begin
                for (int n = 0; n < ewts_pkg::NUM_SLOTS; n++) begin
                    if (slot_state[n] == ewts_pkg::ST_WAIT &&
                        (slot_wait_mask[n] & fired) != '0) begin
                        slot_state[n]     = ewts_pkg::ST_RUN;
                        slot_wait_mask[n] = fired;
                    end
                end
            end
            ewts_pkg::ACT_TICK: begin
                for (int n = 0; n < ewts_pkg::NUM_SLOTS; n++)
                    if (slot_state[n] == ewts_pkg::ST_WAIT && slot_wait_mask[n] == '0)
                        slot_state[n] = ewts_pkg::ST_RUN;
            end
            ewts_pkg::ACT_ABORT: begin
                slot_state[cur] = ewts_pkg::ST_FREE;
                current_q       = next_current();
            end
            default: ;
        endcase
        res.current_index = ewts_pkg::OUT_IDX_W'(current_q);
        res.wake_mask     = ewts_pkg::OUT_MASK_W'(
                                slot_wait_mask[current_q % ewts_pkg::NUM_SLOTS]);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // result side: random stalls and compare with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, actual %0h",
                             $time, {out_bus.status, out_bus.slot_index,
                                     out_bus.current_index, out_bus.wake_mask});
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(out_bus.status));
                    check_field("slot_index", 32'(want.slot_index),
                                32'(out_bus.slot_index));
                    check_field("current_index", 32'(want.current_index),
                                32'(out_bus.current_index));
                    check_field("wake_mask", 32'(want.wake_mask),
                                32'(out_bus.wake_mask));
                    results_checked++;
                end
            end
            out_bus.ready <= ($urandom_range(99) >= snk_gap_pct);
        end
    end

    // one action beat, with random idle cycles ahead of it
    task automatic send_action(input logic [ewts_pkg::ACT_W-1:0] act,
                               input logic [ewts_pkg::IN_MASK_W-1:0] mask);
        t_sched_result res;
        while ($urandom_range(99) < src_gap_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.action       <= act;
        in_bus.trigger_mask <= mask;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
        res = apply_action(act, mask);
        pending_results.push_back(res);
        action_count[act]++;
        if (res.status == ewts_pkg::STAT_FULL)
            full_count++;
    endtask

    // hold the sender until every predicted result has come back
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // undefined codes only, which the block ignores
    task automatic test_idle_actions();
        send_action(ACT_RSVD7, 16'hFFFF);
        send_action(ACT_RSVD6, 16'h0000);
    endtask

    // abort twice from reset so nothing runs, then yield with nothing running
    task automatic test_switch_with_none_running();
        send_action(ewts_pkg::ACT_ABORT, 16'hFFFF);
        send_action(ewts_pkg::ACT_ABORT, 16'h0000);
        send_action(ewts_pkg::ACT_YIELD, 16'h0000);
    endtask

    // zero trigger wakes nothing, tick wakes zero-mask waiters, trigger stores mask
    task automatic test_wake_paths();
        send_action(ewts_pkg::ACT_TRIGGER, 16'h0000);
        send_action(ewts_pkg::ACT_TICK, 16'h0000);
        send_action(ewts_pkg::ACT_YIELD, 16'h8000);
        send_action(ewts_pkg::ACT_TRIGGER, 16'h8000);
    endtask

    // take every slot, then ask for one more
    task automatic test_fill_to_full();
        send_action(ewts_pkg::ACT_URGENT, 16'hFFFF);
        for (int n = 0; n < ewts_pkg::NUM_SLOTS - 2; n++)
            send_action(ewts_pkg::ACT_LATER,
                        ewts_pkg::IN_MASK_W'($urandom_range(16'hFFFF)));
        send_action(ewts_pkg::ACT_URGENT, 16'h0000);
        drain_results();
    endtask

    function automatic logic [ewts_pkg::ACT_W-1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 18) return ewts_pkg::ACT_LATER;
        if (r < 26) return ewts_pkg::ACT_URGENT;
        if (r < 50) return ewts_pkg::ACT_YIELD;
        if (r < 70) return ewts_pkg::ACT_TRIGGER;
        if (r < 80) return ewts_pkg::ACT_TICK;
        if (r < 94) return ewts_pkg::ACT_ABORT;
        if (r < 97) return ACT_RSVD6;
        return ACT_RSVD7;
    endfunction

    // masks biased so that waits and triggers overlap often
    function automatic logic [ewts_pkg::IN_MASK_W-1:0] pick_mask();
        case ($urandom_range(3))
            0:       return '0;
            1:       return ewts_pkg::IN_MASK_W'(1) << $urandom_range(ewts_pkg::IN_MASK_W - 1);
            2:       return ewts_pkg::IN_MASK_W'($urandom_range(15));
            default: return ewts_pkg::IN_MASK_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // random actions; undefined codes do not count toward the item total
    task automatic test_random_phase(input int n_items, input int src_pct, input int snk_pct,
                                     input bit mid_drain);
        int                         sent;
        logic [ewts_pkg::ACT_W-1:0] act;
        sent        = 0;
        src_gap_pct = src_pct;
        snk_gap_pct = snk_pct;
        while (sent < n_items) begin
            act = pick_action();
            send_action(act, pick_mask());
            if (act <= ewts_pkg::ACT_ABORT) begin
                sent++;
                if (mid_drain && sent == n_items / 2)
                    drain_results();
            end
        end
    endtask

    // main sequence
    initial begin
        in_bus.valid        <= 1'b0;
        in_bus.action       <= ewts_pkg::ACT_TICK;
        in_bus.trigger_mask <= '0;
        i_rst_n             <= 1'b0;
        reset_scheduler();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_actions();
        test_switch_with_none_running();
        test_wake_paths();
        test_fill_to_full();
        test_random_phase(142, 11, 49, 1'b1);
        test_random_phase(142, 49, 11, 1'b0);
        test_random_phase(142, 0, 0, 1'b0);

        // let the last results arrive, then watch for strays
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d invokes, %0d yields, %0d triggers, %0d ticks, %0d aborts, %0d undefined",
                 action_count[ewts_pkg::ACT_LATER] + action_count[ewts_pkg::ACT_URGENT],
                 action_count[ewts_pkg::ACT_YIELD], action_count[ewts_pkg::ACT_TRIGGER],
                 action_count[ewts_pkg::ACT_TICK], action_count[ewts_pkg::ACT_ABORT],
                 action_count[ACT_RSVD6] + action_count[ACT_RSVD7]);
        $display("%0d result beats compared, %0d invokes found no free slot",
                 results_checked, full_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
